FILE: design/lrsgd_pkg.sv
// Package for the SGD linear regression trainer: widths, register indexes,
// status codes and fixed-point helpers. No dependencies.
package lrsgd_pkg;

    localparam int MaxSets  = 64;
    localparam int IdxW     = $clog2(MaxSets);
    localparam int CntW     = IdxW + 1;
    localparam int FracBits = 16;

    localparam logic [2:0] REG_EPOCH_LIMIT = 3'd0;
    localparam logic [2:0] REG_RATE        = 3'd1;
    localparam logic [2:0] REG_THRESHOLD   = 3'd2;
    localparam logic [2:0] REG_START_W     = 3'd3;
    localparam logic [2:0] REG_START_B     = 3'd4;
    localparam logic [2:0] REG_SEED        = 3'd5;

    localparam logic [1:0] ST_CONVERGED = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_INVALID   = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    localparam logic [15:0] LfsrTaps = 16'hB400;

    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        if (v > 65'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -65'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

FILE: design/linear_regression_sgd_trainer_unit.sv
// SGD linear regression trainer, top level; depends on lrsgd_pkg.
// Loading: one sample per cycle. Training: an init step, then a pass filling the order memory;
// per epoch a clear step, then per swap an LFSR step, remainder steps, a read and two writes,
// per sample an update (multiplies skipped when x is zero), then the mean error division and check.
// A finished result waits in the output register while the next batch loads.
// Reset is asynchronous and restores register defaults; order memory rebuilt per training.
module linear_regression_sgd_trainer_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [2:0]                   cfg_index,
    input  logic [31:0]                  cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [31:0]           x_value,
    input  logic signed [31:0]           y_reference,
    input  logic                         last_sample,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [31:0]           weight_out,
    output logic signed [31:0]           bias_out,
    output logic [15:0]                  epochs_run,
    output logic [1:0]                   status
);
    import lrsgd_pkg::*;

    typedef enum logic [4:0] {
        S_LOAD, S_INIT, S_ORD, S_EPOCH, S_SH_LFSR, S_SH_MOD, S_SH_RD, S_SH_WR1,
        S_SH_WR2, S_UP_RD, S_UP_RD2, S_UP_RD3, S_UP_M1, S_UP_PRED, S_UP_M2,
        S_UP_B, S_UP_M3, S_UP_W, S_DIV, S_DIV_END, S_OUT
    } state_t;

    state_t state_reg;

    logic [15:0]        epoch_limit_reg, rate_reg, seed_reg;
    logic [30:0]        thr_reg;
    logic signed [31:0] start_w_reg, start_b_reg;

    logic signed [31:0] xmem [MaxSets];
    logic signed [31:0] ymem [MaxSets];
    logic [IdxW-1:0]    omem [MaxSets];

    logic [CntW-1:0]    count_reg, i_reg;
    logic               ovf_reg;
    logic signed [31:0] w_reg, b_reg, x_reg, y_reg;
    logic [47:0]        esum_reg;
    logic [15:0]        lfsr_reg, ep_reg;
    logic [15:0]        mod_reg;
    logic [IdxW-1:0]    r_reg, oi_reg, or_reg, k_reg;
    logic signed [32:0] e_reg;

    // shared multiplier
    logic signed [32:0] ma_reg, mb_reg;
    logic signed [65:0] prod_reg;

    // restoring divider
    logic [47:0] quo_reg, rem_reg;
    logic [5:0]  dcnt_reg;

    logic signed [31:0] wo_reg, bo_reg;
    logic [15:0]        eo_reg;
    logic [1:0]         so_reg;
    logic               ov_reg;

    logic [15:0] lfsr_step;
    logic [47:0] rem_sh;
    logic signed [64:0] pred_sum, w_sum;
    logic signed [32:0] step_now;
    logic signed [33:0] b_sum;
    logic [32:0] e_abs;
    logic        bad_cfg, done_fit, res_load;

    assign lfsr_step = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LfsrTaps) : (lfsr_reg >> 1);
    assign rem_sh    = {rem_reg[46:0], quo_reg[47]};
    assign pred_sum  = 65'(prod_reg >>> FracBits) + 65'(b_reg);
    assign step_now  = 33'(prod_reg >>> 16);
    assign b_sum     = 34'(b_reg) + 34'(step_now);
    assign w_sum     = 65'(w_reg) + 65'(prod_reg >>> FracBits);
    assign e_abs     = e_reg[32] ? 33'(-e_reg) : 33'(e_reg);

    assign bad_cfg  = (epoch_limit_reg == 16'd0) || (rate_reg == 16'd0) || (seed_reg == 16'd0)
                      || (count_reg == '0);
    assign done_fit = (quo_reg < 48'(thr_reg)) || (ep_reg == epoch_limit_reg - 16'd1);
    // a new result may enter the output register once the old one is gone or is taken this cycle
    assign res_load = (!ov_reg || out_ready)
                      && (((state_reg == S_INIT) && (bad_cfg || ovf_reg))
                          || ((state_reg == S_OUT) && done_fit));

    assign cfg_ready  = (state_reg == S_LOAD);
    assign in_ready   = (state_reg == S_LOAD);
    assign out_valid  = ov_reg;
    assign weight_out = wo_reg;
    assign bias_out   = bo_reg;
    assign epochs_run = eo_reg;
    assign status     = so_reg;

    // memories
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD && in_valid && in_ready && count_reg < CntW'(MaxSets))
        begin
            xmem[count_reg[IdxW-1:0]] <= x_value;
            ymem[count_reg[IdxW-1:0]] <= y_reference;
        end
        if (state_reg == S_UP_RD2)
        begin
            x_reg <= xmem[k_reg];
            y_reg <= ymem[k_reg];
        end
        if (state_reg == S_ORD)
            omem[i_reg[IdxW-1:0]] <= i_reg[IdxW-1:0];
        else if (state_reg == S_SH_WR1)
            omem[i_reg[IdxW-1:0]] <= or_reg;
        else if (state_reg == S_SH_WR2)
            omem[r_reg] <= oi_reg;
        if (state_reg == S_SH_RD)
        begin
            oi_reg <= omem[i_reg[IdxW-1:0]];
            or_reg <= omem[r_reg];
        end
        if (state_reg == S_UP_RD)
            k_reg <= omem[i_reg[IdxW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_LOAD;
            epoch_limit_reg <= 16'd1000;
            rate_reg        <= 16'd6554;
            thr_reg         <= 31'd1;
            start_w_reg     <= '0;
            start_b_reg     <= '0;
            seed_reg        <= 16'd44257;
            count_reg       <= '0;
            ovf_reg         <= 1'b0;
            ov_reg          <= 1'b0;
            i_reg           <= '0;
        end
        else
        begin
            if (res_load)
                ov_reg <= 1'b1;
            else if (ov_reg && out_ready)
                ov_reg <= 1'b0;
            prod_reg <= ma_reg * mb_reg;
            unique case (state_reg)
                S_LOAD:
                begin
                    if (cfg_valid)
                    begin
                        unique case (cfg_index)
                            REG_EPOCH_LIMIT: epoch_limit_reg <= cfg_data[15:0];
                            REG_RATE:        rate_reg        <= cfg_data[15:0];
                            REG_THRESHOLD:   thr_reg         <= cfg_data[30:0];
                            REG_START_W:     start_w_reg     <= cfg_data;
                            REG_START_B:     start_b_reg     <= cfg_data;
                            REG_SEED:        seed_reg        <= cfg_data[15:0];
                            default: ;
                        endcase
                    end
                    if (in_valid && in_ready)
                    begin
                        if (count_reg < CntW'(MaxSets))
                            count_reg <= count_reg + 1'b1;
                        else
                            ovf_reg <= 1'b1;
                        if (last_sample)
                            state_reg <= S_INIT;
                    end
                end
                S_INIT:
                begin
                    w_reg    <= start_w_reg;
                    b_reg    <= start_b_reg;
                    lfsr_reg <= seed_reg;
                    ep_reg   <= '0;
                    i_reg    <= '0;
                    if (bad_cfg)
                    begin
                        if (res_load)
                        begin
                            wo_reg <= start_w_reg; bo_reg <= start_b_reg;
                            eo_reg <= '0; so_reg <= ST_INVALID;
                            count_reg <= '0; ovf_reg <= 1'b0;
                            state_reg <= S_LOAD;
                        end
                    end
                    else if (ovf_reg)
                    begin
                        if (res_load)
                        begin
                            wo_reg <= start_w_reg; bo_reg <= start_b_reg;
                            eo_reg <= '0; so_reg <= ST_OVERFLOW;
                            count_reg <= '0; ovf_reg <= 1'b0;
                            state_reg <= S_LOAD;
                        end
                    end
                    else
                        state_reg <= S_ORD;
                end
                S_ORD:
                begin
                    i_reg <= i_reg + 1'b1;
                    if (i_reg == count_reg - 1'b1)
                    begin
                        i_reg <= '0;
                        state_reg <= S_EPOCH;
                    end
                end
                S_EPOCH:
                begin
                    esum_reg  <= '0;
                    i_reg     <= '0;
                    state_reg <= S_SH_LFSR;
                end
                S_SH_LFSR:
                begin
                    lfsr_reg  <= lfsr_step;
                    mod_reg   <= lfsr_step;
                    state_reg <= S_SH_MOD;
                end
                S_SH_MOD:
                begin
                    // remainder by repeated subtraction of shifted count
                    if (mod_reg >= 16'(count_reg) << 9)
                        mod_reg <= mod_reg - (16'(count_reg) << 9);
                    else if (mod_reg >= 16'(count_reg) << 6)
                        mod_reg <= mod_reg - (16'(count_reg) << 6);
                    else if (mod_reg >= 16'(count_reg) << 3)
                        mod_reg <= mod_reg - (16'(count_reg) << 3);
                    else if (mod_reg >= 16'(count_reg))
                        mod_reg <= mod_reg - 16'(count_reg);
                    else
                    begin
                        r_reg     <= mod_reg[IdxW-1:0];
                        state_reg <= S_SH_RD;
                    end
                end
                S_SH_RD:  state_reg <= S_SH_WR1;
                S_SH_WR1: state_reg <= S_SH_WR2;
                S_SH_WR2:
                begin
                    if (i_reg == count_reg - 1'b1)
                    begin
                        i_reg     <= '0;
                        state_reg <= S_UP_RD;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_SH_LFSR;
                    end
                end
                S_UP_RD:  state_reg <= S_UP_RD2;
                S_UP_RD2: state_reg <= S_UP_RD3;
                S_UP_RD3:
                begin
                    if (x_reg == 0)
                    begin
                        b_reg     <= y_reg;
                        state_reg <= S_UP_W;
                    end
                    else
                    begin
                        ma_reg    <= 33'(w_reg);
                        mb_reg    <= 33'(x_reg);
                        state_reg <= S_UP_M1;
                    end
                end
                S_UP_M1: state_reg <= S_UP_PRED;
                S_UP_PRED:
                begin
                    e_reg     <= 33'(y_reg) - 33'(sat32(pred_sum));
                    state_reg <= S_UP_M2;
                end
                S_UP_M2:
                begin
                    ma_reg    <= e_reg;
                    mb_reg    <= 33'({1'b0, rate_reg});
                    esum_reg  <= esum_reg + 48'(e_abs);
                    state_reg <= S_UP_B;
                end
                S_UP_B:
                begin
                    // wait for the registered product
                    state_reg <= S_UP_M3;
                end
                S_UP_M3:
                begin
                    b_reg     <= sat32(65'(b_sum));
                    ma_reg    <= step_now;
                    mb_reg    <= 33'(x_reg);
                    state_reg <= S_DIV_END;
                end
                S_DIV_END:
                begin
                    // product of step*x available next cycle
                    state_reg <= S_UP_W;
                    i_reg     <= i_reg;
                end
                S_UP_W:
                begin
                    if (x_reg != 0)
                        w_reg <= sat32(w_sum);
                    if (i_reg == count_reg - 1'b1)
                    begin
                        quo_reg   <= esum_reg;
                        rem_reg   <= '0;
                        dcnt_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_UP_RD;
                    end
                end
                S_DIV:
                begin
                    if (rem_sh >= 48'(count_reg))
                    begin
                        rem_reg <= rem_sh - 48'(count_reg);
                        quo_reg <= {quo_reg[46:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[46:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == 6'd47)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (done_fit)
                    begin
                        if (res_load)
                        begin
                            wo_reg <= w_reg; bo_reg <= b_reg;
                            if (quo_reg < 48'(thr_reg))
                            begin
                                eo_reg <= ep_reg;
                                so_reg <= ST_CONVERGED;
                            end
                            else
                            begin
                                eo_reg <= epoch_limit_reg;
                                so_reg <= ST_EXHAUSTED;
                            end
                            count_reg <= '0; ovf_reg <= 1'b0;
                            state_reg <= S_LOAD;
                        end
                    end
                    else
                    begin
                        ep_reg    <= ep_reg + 1'b1;
                        state_reg <= S_EPOCH;
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

endmodule
